// ----- rtl/core/dws_pkg.sv -----
// shared types, constants and pointer helpers for the deque with search
// no dependencies
package dws_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [VALUE_BITS-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_DROP_FRONT = 3'd2,
		CMD_DROP_BACK  = 3'd3,
		CMD_SEARCH     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		word_t data;
	} wr_req_t;

	typedef struct packed {
		logic en;
		idx_t addr;
	} rd_req_t;

	function automatic idx_t idx_inc(idx_t p);
		return (p == idx_t'(DEPTH - 1)) ? '0 : idx_t'(p + 1'b1);
	endfunction

	function automatic idx_t idx_dec(idx_t p);
		return (p == '0) ? idx_t'(DEPTH - 1) : idx_t'(p - 1'b1);
	endfunction

	// sign-extend or truncate the 32-bit port value to the stored width
	function automatic word_t fit_value(logic signed [31:0] v);
		return VALUE_BITS'(v);
	endfunction

endpackage

// ----- rtl/core/dws_store.sv -----
// circular entry store: one write port, one read port with registered data
// depends on dws_pkg
module dws_store
	import dws_pkg::*;
(
	input  logic    clk,
	input  wr_req_t wr,
	input  rd_req_t rd,
	output word_t   rd_data
);

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ----- rtl/core/deque_with_search.sv -----
// deque with search: pushes and drops complete in the cycle after the transaction,
// strobe high in that cycle; busy stays low so a command can follow every cycle
// search: one store read per cycle through the single read port and comparator,
// result strobe once a hit is seen or all entries are read, busy high meanwhile
// arst_n clears the pointers and count to an empty store; entries are not cleared
// depends on dws_pkg, dws_store
module deque_with_search
	import dws_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] value,
	output logic               strobe,
	output logic [1:0]         status,
	output logic               found,
	output logic [6:0]         count
);

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	state_t  state_q;
	idx_t    front_q;
	idx_t    back_q;
	idx_t    rp_q;
	cnt_t    cnt_q;
	cnt_t    k_q;
	logic    rd_vld_s1;
	logic    strobe_q;
	status_t status_q;
	logic    found_q;
	word_t   key_q;

	wr_req_t wr;
	rd_req_t rd;
	word_t   rd_data;
	logic    accept;
	logic    full;
	logic    empty;
	logic    hit;
	logic    issue;
	logic    finish;
	cmd_t    cmd_in;

	assign cmd_in = cmd_t'(cmd);
	assign accept = start && (state_q == S_IDLE);
	assign full   = (cnt_q == cnt_t'(DEPTH));
	assign empty  = (cnt_q == '0);

	// shared comparator on the registered read data
	assign hit    = rd_vld_s1 && (rd_data == key_q);
	assign issue  = (state_q == S_SEARCH) && !hit && (k_q != cnt_q);
	assign finish = hit || ((k_q == cnt_q) && !rd_vld_s1);

	always_comb begin
		wr.en   = accept && !full &&
			((cmd_in == CMD_PUSH_FRONT) || (cmd_in == CMD_PUSH_BACK));
		wr.addr = (cmd_in == CMD_PUSH_FRONT) ? idx_dec(front_q) : back_q;
		wr.data = fit_value(value);
		rd.en   = issue;
		rd.addr = rp_q;
	end

	dws_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= fit_value(value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			front_q   <= '0;
			back_q    <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			rd_vld_s1 <= 1'b0;
			strobe_q  <= 1'b0;
			status_q  <= ST_DONE;
			found_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						strobe_q <= 1'b1;
						status_q <= ST_DONE;
						found_q  <= 1'b0;
						case (cmd_in)
							CMD_PUSH_FRONT: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									front_q <= idx_dec(front_q);
									cnt_q   <= cnt_t'(cnt_q + 1'b1);
								end
							end
							CMD_PUSH_BACK: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									back_q <= idx_inc(back_q);
									cnt_q  <= cnt_t'(cnt_q + 1'b1);
								end
							end
							CMD_DROP_FRONT: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									front_q <= idx_inc(front_q);
									cnt_q   <= cnt_t'(cnt_q - 1'b1);
								end
							end
							CMD_DROP_BACK: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									back_q <= idx_dec(back_q);
									cnt_q  <= cnt_t'(cnt_q - 1'b1);
								end
							end
							CMD_SEARCH: begin
								strobe_q  <= 1'b0;
								rp_q      <= front_q;
								k_q       <= '0;
								rd_vld_s1 <= 1'b0;
								state_q   <= S_SEARCH;
							end
							default: ;
						endcase
					end
				end
				S_SEARCH: begin
					if (finish) begin
						strobe_q  <= 1'b1;
						status_q  <= ST_DONE;
						found_q   <= hit;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_IDLE;
					end else begin
						rd_vld_s1 <= issue;
						if (issue) begin
							rp_q <= idx_inc(rp_q);
							k_q  <= cnt_t'(k_q + 1'b1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign status = status_q;
	assign found  = found_q;
	assign count  = 7'(cnt_q);

endmodule

// ----- rtl/core/deque_with_search_chk.sv -----
// port-level checker for the deque with search, bound to the top level
// depends on dws_pkg, deque_with_search
module deque_with_search_chk
	import dws_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         cmd,
	input logic signed [31:0] value,
	input logic               strobe,
	input logic [1:0]         status,
	input logic               found,
	input logic [6:0]         count
);

	// a non-search transaction answers in the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd != CMD_SEARCH)) |=> strobe)
		else $error("push, drop or unused command gave no result next cycle");

	// a search transaction holds the block busy
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_SEARCH)) |=> (busy && !strobe))
		else $error("search did not hold busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_FULL)) |-> (count == 7'(DEPTH)) && !found)
		else $error("refused push with store not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (status == ST_EMPTY)) |-> (count == 7'd0) && !found)
		else $error("refused drop with store not empty");

	// count only changes along with a result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!strobe |=> ((count == $past(count)) || strobe))
		else $error("count changed without a result");

endmodule

bind deque_with_search deque_with_search_chk u_chk (.*);
